@@ rtl/mpq_pkg.sv @@
// shared types and codes for the max priority queue
package mpq_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

@@ rtl/mpq_cell.sv @@
// one slot of the sorted shift array
module mpq_cell (
  input  logic                                 clk,
  input  mpq_pkg::cell_ctl_t                   ctl,
  input  logic                                 occupied,
  input  logic signed [mpq_pkg::VALUE_W-1:0]   new_value,
  input  logic                                 left_keep,
  input  logic signed [mpq_pkg::VALUE_W-1:0]   left_value,
  input  logic signed [mpq_pkg::VALUE_W-1:0]   right_value,
  output logic                                 keep,
  output logic signed [mpq_pkg::VALUE_W-1:0]   value
);

  logic signed [mpq_pkg::VALUE_W-1:0] value_next;

  // equal values stay ahead of a new one, so ties leave in arrival order
  assign keep = occupied && (value >= new_value);

  always_comb begin
    value_next = value;
    if (ctl.del) begin
      value_next = right_value;
    end else if (ctl.ins && !keep) begin
      if (left_keep) begin
        value_next = new_value;
      end else begin
        value_next = left_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

@@ rtl/max_priority_queue.sv @@
// max priority queue top level: sorted cell row, occupancy count and result register
// The queue keeps up to CAPACITY signed values in a row of cells sorted from largest
// to smallest, equal values in arrival order. An insert is placed by every cell at
// once comparing against the new value and shifting one place down; a delete-max takes
// the head cell and shifts the row up. Either finishes in the cycle it is accepted, so one
// transfer is taken per cycle unless a result stalls, and its result shows in the next cycle.
// Input ready drops only while a result waits in the output register and is not taken.
module max_priority_queue #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                action,
  input  logic signed [mpq_pkg::VALUE_W-1:0]  item_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          status,
  output logic signed [mpq_pkg::VALUE_W-1:0]  removed_value,
  output logic [CNT_W-1:0]                    occupancy
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             fire;
  logic             full;
  logic             empty;
  logic             do_ins;
  logic             do_del;
  mpq_pkg::cell_ctl_t ctl;

  logic signed [mpq_pkg::VALUE_W-1:0] cell_value [CAPACITY];
  logic                               cell_keep  [CAPACITY];
  logic                               cell_occ   [CAPACITY];

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign do_ins   = fire && !action && !full;
  assign do_del   = fire && action && !empty;
  assign ctl.ins  = do_ins;
  assign ctl.del  = do_del;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                               lk;
      logic signed [mpq_pkg::VALUE_W-1:0] lv;
      logic signed [mpq_pkg::VALUE_W-1:0] rv;

      assign cell_occ[i] = (count > CNT_W'(i));

      if (i == 0) begin : g_head
        assign lk = 1'b1;
        assign lv = item_value;
      end else begin : g_body
        assign lk = cell_keep[i-1];
        assign lv = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign rv = cell_value[i];
      end else begin : g_inner
        assign rv = cell_value[i+1];
      end

      mpq_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .occupied    (cell_occ[i]),
        .new_value   (item_value),
        .left_keep   (lk),
        .left_value  (lv),
        .right_value (rv),
        .keep        (cell_keep[i]),
        .value       (cell_value[i])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CNT_W'(1);
    end else if (do_del) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      occupancy <= count_next;
      if (!action) begin
        status        <= full ? mpq_pkg::ST_OVERFLOW : mpq_pkg::ST_DONE;
        removed_value <= '0;
      end else if (empty) begin
        status        <= mpq_pkg::ST_UNDERFLOW;
        removed_value <= '0;
      end else begin
        status        <= mpq_pkg::ST_DONE;
        removed_value <= cell_value[0];
      end
    end
  end

endmodule

@@ rtl/mpq_checker.sv @@
// port-level checks for the max priority queue, bound to the top level
module mpq_checker #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [1:0]                          status,
  input logic signed [mpq_pkg::VALUE_W-1:0]  removed_value,
  input logic [CNT_W-1:0]                    occupancy
);

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(removed_value) && $stable(occupancy))
    else $error("stalled result changed");

  a_underflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mpq_pkg::ST_UNDERFLOW |-> occupancy == '0 && removed_value == '0)
    else $error("underflow with nonempty queue or nonzero value");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mpq_pkg::ST_OVERFLOW |->
      occupancy == CNT_W'(CAPACITY) && removed_value == '0)
    else $error("overflow on a queue that is not full");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind max_priority_queue mpq_checker #(.CAPACITY(CAPACITY)) u_mpq_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .removed_value (removed_value),
  .occupancy     (occupancy)
);
